// ===== hdl/pfm_pkg.sv =====
// pfm_pkg: widths, register indexes and reset values for the pulse flow meter
// no dependencies; used by the interfaces, the top level and the checker
package pfm_pkg;

  localparam int COUNT_BITS = 20;
  localparam int INTERVAL_W = 16;
  localparam int RPP_W      = 24;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int RATE_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // shift-add accumulators: product of count and rate_per_pulse, and the average sum
  localparam int P1_W   = COUNT_BITS + RPP_W;
  localparam int P2_W   = RATE_W + 1 + ALPHA_W;
  localparam int RND_W  = P2_W - ALPHA_FRAC + 2;
  localparam int STEPS  = (COUNT_BITS > ALPHA_W) ? COUNT_BITS : ALPHA_W;
  localparam int STEP_W = $clog2(STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RPP      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LEAK     = CFG_IDX_W'(3);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(1000);
  localparam logic [RPP_W-1:0]      RPP_RST      = RPP_W'(8738);
  localparam logic [ALPHA_W-1:0]    ALPHA_RST    = ALPHA_W'(6554);
  localparam logic [RATE_W-1:0]     LEAK_RST     = RATE_W'(65536);
  localparam logic [ALPHA_W-1:0]    ALPHA_ONE    = ALPHA_W'(65536);

  typedef logic [RATE_W-1:0] rate_t;

endpackage

// ===== hdl/pfm_if.sv =====
// pfm_if: valid/ready channels of the pulse flow meter (samples, results, config)
// depends on pfm_pkg
interface pfm_sample_if;
  logic valid;
  logic ready;
  logic pulse_edge;
  logic ms_tick;
  modport source (output valid, pulse_edge, ms_tick, input ready);
  modport sink (input valid, pulse_edge, ms_tick, output ready);
endinterface

interface pfm_result_if;
  logic           valid;
  logic           ready;
  pfm_pkg::rate_t flow_rate;
  pfm_pkg::rate_t filtered_flow;
  logic           leak_detected;
  logic           new_measurement;
  modport source (output valid, flow_rate, filtered_flow, leak_detected, new_measurement,
                  input ready);
  modport sink (input valid, flow_rate, filtered_flow, leak_detected, new_measurement,
                output ready);
endinterface

interface pfm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfm_pkg::CFG_IDX_W-1:0]  index;
  logic [pfm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pulse_flow_meter_ema.sv =====
// pulse_flow_meter_ema: the result of an item that leaves the window open is registered
// and shown in the next cycle; an item that closes the window runs ST_MUL, then ST_EMA:
// one bit-serial shift-add pass over the edge count, then one over the 17-bit alpha.
// throughput: one item per cycle while no window closes and results are taken.
// rst is synchronous: registers take their defaults, counters and rates clear.
// depends on pfm_pkg and pfm_if
module pulse_flow_meter_ema (
  input  logic         clk,
  input  logic         rst,
  pfm_sample_if.sink   sample,
  pfm_result_if.source result,
  pfm_cfg_if.sink      cfg
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMA  = 2'd2;

  logic [pfm_pkg::INTERVAL_W-1:0] interval_ms;
  logic [pfm_pkg::RPP_W-1:0]      rate_per_pulse;
  logic [pfm_pkg::ALPHA_W-1:0]    alpha;
  pfm_pkg::rate_t                 leak_threshold;

  logic [pfm_pkg::COUNT_BITS-1:0] edge_count;
  logic [pfm_pkg::INTERVAL_W-1:0] elapsed_ms;
  pfm_pkg::rate_t                 raw_rate;
  pfm_pkg::rate_t                 smoothed_rate;

  logic [1:0]                  state;
  logic [pfm_pkg::STEP_W-1:0]  step;
  logic [pfm_pkg::P1_W-1:0]    acc1;
  logic [pfm_pkg::P2_W-1:0]    acc2;
  logic [pfm_pkg::ALPHA_W-1:0] wa;
  logic [pfm_pkg::ALPHA_W-1:0] wb;

  logic           out_valid;
  pfm_pkg::rate_t out_flow;
  pfm_pkg::rate_t out_filtered;
  logic           out_leak;
  logic           out_new;

  logic                           accept;
  logic                           load_out;
  logic [pfm_pkg::INTERVAL_W-1:0] elapsed_next;
  logic [pfm_pkg::COUNT_BITS-1:0] edge_count_next;
  logic                           close;
  logic [pfm_pkg::ALPHA_W-1:0]    alpha_eff;

  logic [pfm_pkg::RPP_W:0]    sum1;
  logic [pfm_pkg::P1_W-1:0]   acc1_next;
  logic [pfm_pkg::P1_W:0]     acc1_ext;
  pfm_pkg::rate_t             raw_sat;
  logic [pfm_pkg::RATE_W+1:0] sum2;
  logic [pfm_pkg::P2_W-1:0]   acc2_next;
  logic [pfm_pkg::RND_W-1:0]  rnd;
  pfm_pkg::rate_t             smoothed_next;

  assign sample.ready = (state == ST_IDLE) && (!out_valid || result.ready);
  assign accept       = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;

  assign result.valid           = out_valid;
  assign result.flow_rate       = out_flow;
  assign result.filtered_flow   = out_filtered;
  assign result.leak_detected   = out_leak;
  assign result.new_measurement = out_new;

  // both counters saturate at all ones
  assign elapsed_next = elapsed_ms
                      + pfm_pkg::INTERVAL_W'(sample.ms_tick && (elapsed_ms != '1));
  assign edge_count_next = edge_count
                         + pfm_pkg::COUNT_BITS'(sample.pulse_edge && (edge_count != '1));
  assign close = elapsed_next >= interval_ms;

  // a new result this cycle takes the place of one that is being taken
  assign load_out = ((state == ST_IDLE) && accept && !close)
                 || ((state == ST_EMA) && (step == pfm_pkg::STEP_W'(pfm_pkg::ALPHA_W - 1)));

  // any alpha with the top bit set is at or above one
  assign alpha_eff = alpha[pfm_pkg::ALPHA_W-1] ? pfm_pkg::ALPHA_ONE : alpha;

  // count * rate_per_pulse, multiplier bits shift out of the low end of acc1
  always_comb begin
    sum1 = {1'b0, acc1[pfm_pkg::P1_W-1:pfm_pkg::COUNT_BITS]}
         + (acc1[0] ? {1'b0, rate_per_pulse} : '0);
    acc1_next = {sum1, acc1[pfm_pkg::COUNT_BITS-1:1]};
    acc1_ext  = {1'b0, acc1_next};
    raw_sat   = (|acc1_ext[pfm_pkg::P1_W:pfm_pkg::RATE_W]) ? '1
              : acc1_ext[pfm_pkg::RATE_W-1:0];
  end

  // alpha*raw + (one-alpha)*smoothed, both weights stepped a bit per cycle
  always_comb begin
    sum2 = {1'b0, acc2[pfm_pkg::P2_W-1:pfm_pkg::ALPHA_W]}
         + (wa[0] ? {2'b00, raw_rate} : '0)
         + (wb[0] ? {2'b00, smoothed_rate} : '0);
    acc2_next = {sum2, acc2[pfm_pkg::ALPHA_W-1:1]};
    // round half up, drop the 16 fraction bits of alpha
    rnd = {1'b0, acc2_next[pfm_pkg::P2_W-1:pfm_pkg::ALPHA_FRAC-1]} + pfm_pkg::RND_W'(1);
    smoothed_next = rnd[pfm_pkg::RATE_W:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms    <= pfm_pkg::INTERVAL_RST;
      rate_per_pulse <= pfm_pkg::RPP_RST;
      alpha          <= pfm_pkg::ALPHA_RST;
      leak_threshold <= pfm_pkg::LEAK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pfm_pkg::REG_INTERVAL: interval_ms    <= cfg.data[pfm_pkg::INTERVAL_W-1:0];
        pfm_pkg::REG_RPP:      rate_per_pulse <= cfg.data[pfm_pkg::RPP_W-1:0];
        pfm_pkg::REG_ALPHA:    alpha          <= cfg.data[pfm_pkg::ALPHA_W-1:0];
        pfm_pkg::REG_LEAK:     leak_threshold <= cfg.data[pfm_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      edge_count    <= '0;
      elapsed_ms    <= '0;
      raw_rate      <= '0;
      smoothed_rate <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && result.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (close) begin
              edge_count <= '0;
              elapsed_ms <= '0;
              acc1       <= {{pfm_pkg::RPP_W{1'b0}}, edge_count_next};
              step       <= '0;
              state      <= ST_MUL;
            end else begin
              edge_count   <= edge_count_next;
              elapsed_ms   <= elapsed_next;
              out_valid    <= 1'b1;
              out_flow     <= raw_rate;
              out_filtered <= smoothed_rate;
              out_leak     <= smoothed_rate > leak_threshold;
              out_new      <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          acc1 <= acc1_next;
          if (step == pfm_pkg::STEP_W'(pfm_pkg::COUNT_BITS - 1)) begin
            raw_rate <= raw_sat;
            acc2     <= '0;
            wa       <= alpha_eff;
            wb       <= pfm_pkg::ALPHA_ONE - alpha_eff;
            step     <= '0;
            state    <= ST_EMA;
          end else begin
            step <= step + pfm_pkg::STEP_W'(1);
          end
        end
        ST_EMA: begin
          acc2 <= acc2_next;
          wa   <= wa >> 1;
          wb   <= wb >> 1;
          step <= step + pfm_pkg::STEP_W'(1);
          if (step == pfm_pkg::STEP_W'(pfm_pkg::ALPHA_W - 1)) begin
            smoothed_rate <= smoothed_next;
            out_valid     <= 1'b1;
            out_flow      <= raw_rate;
            out_filtered  <= smoothed_next;
            out_leak      <= smoothed_next > leak_threshold;
            out_new       <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pfm_checker.sv =====
// pfm_checker: port-level checks of the pulse flow meter, bound to the top level
// depends on pfm_pkg and pulse_flow_meter_ema
module pfm_checker (
  input logic           clk,
  input logic           rst,
  input logic           s_valid,
  input logic           s_ready,
  input logic           r_valid,
  input logic           r_ready,
  input pfm_pkg::rate_t flow_rate,
  input pfm_pkg::rate_t filtered_flow,
  input logic           leak_detected,
  input logic           new_measurement
);

  // a waiting result blocks the next item
  a_no_accept_while_stalled: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |-> !(s_valid && s_ready))
    else $error("item accepted while a result is stalled");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result dropped before it was taken");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> $stable(flow_rate) && $stable(filtered_flow)
                            && $stable(leak_detected) && $stable(new_measurement))
    else $error("stalled result changed");

  // a zero average can never lie above the threshold
  a_leak_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && (filtered_flow == '0) |-> !leak_detected)
    else $error("leak flagged with zero filtered flow");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !r_valid)
    else $error("result valid right after reset");

endmodule

bind pulse_flow_meter_ema pfm_checker u_pfm_checker (
  .clk             (clk),
  .rst             (rst),
  .s_valid         (sample.valid),
  .s_ready         (sample.ready),
  .r_valid         (result.valid),
  .r_ready         (result.ready),
  .flow_rate       (result.flow_rate),
  .filtered_flow   (result.filtered_flow),
  .leak_detected   (result.leak_detected),
  .new_measurement (result.new_measurement)
);
